// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the deframer back end (iqd_back).
// Properties are clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain clocked property with reset disable
`define IQD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("iqd assertion failed");

// Same-cycle implication
`define IQD_ASSERT_IMPL(lbl, ante, cons) \
    `IQD_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication
`define IQD_ASSERT_NEXT(lbl, ante, cons) \
    `IQD_ASSERT(lbl, (ante) |=> (cons))

`else

`define IQD_ASSERT(lbl, prop)
`define IQD_ASSERT_IMPL(lbl, ante, cons)
`define IQD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/iqd_pkg.sv =====
// Shared types and constants for the I/Q sync-word byte deframer.
// No dependencies.
package iqd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int THR_W    = 15;
    localparam int HDR_W    = 9;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THR_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_INV  = 2'd2;

    // Reset values of the registers
    localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd1200;
    localparam logic [HDR_W-1:0] SYNC_RST      = 9'b110101011;
    localparam logic [HDR_W-1:0] SYNC_INV_RST  = 9'b001010100;

    // Last bit position of a data byte
    localparam logic [2:0] LAST_BIT = 3'd7;

    // One qualified sample, already classified
    typedef struct packed {
        logic pos;  // at or above +threshold
        logic neg;  // at or below -threshold
    } t_bit_item;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

// ===== hw/rtl/iq_sync_word_byte_deframer_core.sv =====
// I/Q sync-word byte deframer: usage
// Input channel: one I/Q sample per word on i_sample_i / i_sample_q, taken at a
// rising edge with i_valid high and o_stall low. Samples whose stronger
// component is below the threshold are dropped at the front stage.
// Output channel: one recovered byte per word on o_data_byte with
// o_polarity_inverted, handed over on a rising edge with o_valid high and
// i_stall low. Nothing is produced for header bits.
// Config: i_cfg_valid / o_cfg_ready write port; index 0 threshold, 1 sync
// header, 2 inverted header; other indexes are ignored. o_cfg_ready is always
// high. Write only while the block is idle.
// Throughput: one sample per cycle while o_stall is low, set by the classify stage and
// one bit consumed per cycle by the header/byte sequencer while the output is not stalled.
// Path to o_valid: with the queue empty, the sample carrying the last bit passes the
// front register, then the queue, then the output register.
// Reset (synchronous, i_rst_n low) restores the register defaults, empties the
// queue and restarts the header hunt.
// When the receiver stalls a waiting byte, the byte holds and no bits are taken; the front
// register and queue absorb FifoDepth + 1 qualified samples before o_stall rises.
// Depends on iqd_pkg, iqd_front, iqd_fifo, iqd_back.
module iq_sync_word_byte_deframer_core import iqd_pkg::*; #(
    parameter int FifoDepth = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_i,
    input  logic signed [SAMPLE_W-1:0] i_sample_q,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [BYTE_W-1:0]          o_data_byte,
    output logic                       o_polarity_inverted,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [THR_W-1:0] r_threshold;
    logic [HDR_W-1:0] r_sync;
    logic [HDR_W-1:0] r_sync_inv;
    t_fifo_stat       fifo_stat;
    t_bit_item        push_item;
    t_bit_item        pop_item;
    logic             push;
    logic             pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_sync      <= SYNC_RST;
            r_sync_inv  <= SYNC_INV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_IDX_SYNC:      r_sync      <= i_cfg_data[HDR_W-1:0];
                CFG_IDX_SYNC_INV:  r_sync_inv  <= i_cfg_data[HDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    iqd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .i_threshold (r_threshold),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_item      (push_item)
    );

    iqd_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (fifo_stat)
    );

    iqd_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fifo_stat         (fifo_stat),
        .i_item              (pop_item),
        .o_pop               (pop),
        .i_sync              (r_sync),
        .i_sync_inv          (r_sync_inv),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_data_byte         (o_data_byte),
        .o_polarity_inverted (o_polarity_inverted)
    );

endmodule

// ===== hw/rtl/iqd_front.sv =====
// Front end: picks the stronger of I and Q, applies the threshold and
// classifies the sample. Depends on iqd_pkg.
module iqd_front import iqd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_i,
    input  logic signed [SAMPLE_W-1:0] i_sample_q,
    input  logic [THR_W-1:0]           i_threshold,
    input  t_fifo_stat                 i_fifo_stat,
    output logic                       o_push,
    output t_bit_item                  o_item
);

    logic [MAG_W-1:0] mag_i;
    logic [MAG_W-1:0] mag_q;
    logic [MAG_W-1:0] mag_a;
    logic             sign_a;
    logic             qualified;
    logic             r_valid;
    t_bit_item        r_item;
    t_bit_item        n_item;

    // Magnitudes in 17 bits so full-scale negative stays exact
    always_comb begin
        mag_i = i_sample_i[SAMPLE_W-1] ? MAG_W'(-{i_sample_i[SAMPLE_W-1], i_sample_i})
                                       : MAG_W'({i_sample_i[SAMPLE_W-1], i_sample_i});
        mag_q = i_sample_q[SAMPLE_W-1] ? MAG_W'(-{i_sample_q[SAMPLE_W-1], i_sample_q})
                                       : MAG_W'({i_sample_q[SAMPLE_W-1], i_sample_q});
    end

    // Q wins ties
    always_comb begin
        if (mag_i > mag_q) begin
            mag_a  = mag_i;
            sign_a = i_sample_i[SAMPLE_W-1];
        end else begin
            mag_a  = mag_q;
            sign_a = i_sample_q[SAMPLE_W-1];
        end
        qualified  = mag_a >= MAG_W'(i_threshold);
        // Once qualified, sign alone decides; zero counts both ways
        n_item.pos = !sign_a;
        n_item.neg = sign_a || (mag_a == '0);
    end

    // Stage register ahead of the queue
    assign o_stall = r_valid && i_fifo_stat.full;
    assign o_push  = r_valid && !i_fifo_stat.full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid && qualified;
        end
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hw/rtl/iqd_fifo.sv =====
// Short queue of classified bits between front and back.
// Depends on iqd_pkg.
module iqd_fifo import iqd_pkg::*; #(
    parameter int Depth = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_bit_item  i_item,
    input  logic       i_pop,
    output t_bit_item  o_item,
    output t_fifo_stat o_stat
);

    localparam int AW = $clog2(Depth);
    localparam int CW = AW + 1;

    t_bit_item       r_mem [Depth];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(Depth));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_item       = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/iqd_back.sv =====
// Back end: header hunt, byte assembly and output register.
// Depends on iqd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iqd_back import iqd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_stat        i_fifo_stat,
    input  t_bit_item         i_item,
    output logic              o_pop,
    input  logic [HDR_W-1:0]  i_sync,
    input  logic [HDR_W-1:0]  i_sync_inv,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic              o_polarity_inverted
);

    logic              r_hunt;
    logic              n_hunt;
    logic [HDR_W-1:0]  r_window;
    logic [HDR_W-1:0]  n_window;
    logic              r_inv;
    logic              n_inv;
    logic [2:0]        r_bit_cnt;
    logic [2:0]        n_bit_cnt;
    logic [BYTE_W-1:0] r_shift;
    logic [BYTE_W-1:0] n_shift;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_pol;
    logic [HDR_W-1:0]  window_nx;
    logic [BYTE_W-1:0] shift_nx;
    logic              data_bit;
    logic              emit;

    // Take a bit whenever one is queued and the output register can accept a byte
    assign o_pop     = !i_fifo_stat.empty && !(r_out_valid && i_stall);
    assign window_nx = {r_window[HDR_W-2:0], i_item.pos};
    assign data_bit  = r_inv ? i_item.neg : i_item.pos;
    assign shift_nx  = {r_shift[BYTE_W-2:0], data_bit};

    // Hunt / gather sequencing
    always_comb begin
        n_hunt    = r_hunt;
        n_window  = r_window;
        n_inv     = r_inv;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        emit      = 1'b0;
        if (o_pop) begin
            if (r_hunt) begin
                n_window = window_nx;
                if ((window_nx == i_sync) || (window_nx == i_sync_inv)) begin
                    // normal polarity wins when both headers match
                    n_inv     = (window_nx != i_sync);
                    n_window  = '0;
                    n_hunt    = 1'b0;
                    n_bit_cnt = '0;
                    n_shift   = '0;
                end
            end else begin
                n_bit_cnt = r_bit_cnt + 1'b1;
                n_shift   = shift_nx;
                if (r_bit_cnt == LAST_BIT) begin
                    emit   = 1'b1;
                    n_hunt = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt      <= 1'b1;
            r_window    <= '0;
            r_inv       <= 1'b0;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hunt    <= n_hunt;
            r_window  <= n_window;
            r_inv     <= n_inv;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        // Output payload
        if (emit) begin
            r_byte <= shift_nx;
            r_pol  <= r_inv;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_data_byte         = r_byte;
    assign o_polarity_inverted = r_pol;

    // A byte only leaves after the eighth data bit
    `IQD_ASSERT_NEXT(a_emit_after_eight, emit, r_out_valid && r_hunt && (r_bit_cnt == '0))
    // Never pull a bit while a stalled byte is still waiting
    `IQD_ASSERT_IMPL(a_no_pop_on_stall, r_out_valid && i_stall, !o_pop)
    // A header match always starts a fresh byte
    `IQD_ASSERT_NEXT(a_hdr_clears, o_pop && r_hunt && !n_hunt,
                     (r_bit_cnt == '0) && (r_shift == '0) && (r_window == '0))

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for iq_sync_word_byte_deframer_core: I/Q words carrying sync
// headers and data bits, checked against a bit-accurate deframe predictor.
// Depends on iqd_pkg and the deframer RTL.
module testbench;
    import iqd_pkg::*;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 250;

    typedef struct packed {
        logic [SAMPLE_W-1:0] i_part;
        logic [SAMPLE_W-1:0] q_part;
    } t_iq_word;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              inverted;
    } t_rx_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample_i = '0;
    logic [SAMPLE_W-1:0]   i_sample_q = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [BYTE_W-1:0]     o_data_byte;
    logic                  o_polarity_inverted;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    iq_sync_word_byte_deframer_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_sample_i          (i_sample_i),
        .i_sample_q          (i_sample_q),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_data_byte         (o_data_byte),
        .o_polarity_inverted (o_polarity_inverted),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Pending words, expected bytes, error tally
    t_iq_word sample_fifo[$];
    t_rx_byte predicted_bytes[$];
    int       mismatches = 0;
    bit       quiet_mode = 1'b0;

    // Register values the stimulus is shaped for
    logic [THR_W-1:0] stim_thr  = THRESHOLD_RST;
    logic [HDR_W-1:0] stim_sync = SYNC_RST;
    logic [HDR_W-1:0] stim_inv  = SYNC_INV_RST;

    // Predictor copy of registers and deframer state
    logic [THR_W-1:0]  thr_reg;
    logic [HDR_W-1:0]  sync_reg;
    logic [HDR_W-1:0]  sync_inv_reg;
    logic              hunt_active;
    logic [HDR_W-1:0]  hdr_window;
    logic              inv_polarity;
    logic [3:0]        bits_taken;
    logic [BYTE_W-1:0] data_shift;

    function automatic void restore_predictor();
        thr_reg      = THRESHOLD_RST;
        sync_reg     = SYNC_RST;
        sync_inv_reg = SYNC_INV_RST;
        hunt_active  = 1'b1;
        hdr_window   = '0;
        inv_polarity = 1'b0;
        bits_taken   = '0;
        data_shift   = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IDX_THRESHOLD: thr_reg      = val[THR_W-1:0];
            CFG_IDX_SYNC:      sync_reg     = val[HDR_W-1:0];
            CFG_IDX_SYNC_INV:  sync_inv_reg = val[HDR_W-1:0];
            default: ;
        endcase
    endfunction

    // One accepted word; returns 1 when it completes a byte
    function automatic bit deframe_sample(input logic [SAMPLE_W-1:0] s_i,
                                          input logic [SAMPLE_W-1:0] s_q,
                                          output t_rx_byte result);
        int vi, vq, mi, mq, a, ma, th;
        bit pos, neg, data_bit;
        result = '0;
        vi = int'($signed(s_i));
        vq = int'($signed(s_q));
        mi = (vi < 0) ? -vi : vi;
        mq = (vq < 0) ? -vq : vq;
        // stronger component wins, Q on a tie
        a  = (mi > mq) ? vi : vq;
        ma = (a < 0) ? -a : a;
        th = int'(thr_reg);
        pos = (a >= th);
        neg = (a <= -th);
        if (ma < th) return 1'b0;

        if (hunt_active) begin
            hdr_window = {hdr_window[HDR_W-2:0], pos};
            // normal header wins when both match
            if (hdr_window == sync_reg || hdr_window == sync_inv_reg) begin
                inv_polarity = (hdr_window != sync_reg);
                hdr_window   = '0;
                hunt_active  = 1'b0;
                bits_taken   = '0;
                data_shift   = '0;
            end
            return 1'b0;
        end

        data_bit   = inv_polarity ? neg : pos;
        bits_taken = bits_taken + 4'd1;
        data_shift = {data_shift[BYTE_W-2:0], data_bit};
        if (bits_taken > 4'd7) begin
            result.value    = data_shift;
            result.inverted = inv_polarity;
            hunt_active     = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Sample driver: random gap bursts, payload held while stalled
    int       send_gap = 0;
    t_iq_word next_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || !o_stall) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 11);
                i_valid  <= 1'b0;
            end else if (sample_fifo.size() != 0) begin
                next_word  = sample_fifo.pop_front();
                i_sample_i <= next_word.i_part;
                i_sample_q <= next_word.q_part;
                i_valid    <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure in bursts
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Byte checker and predictor update
    t_rx_byte want;
    t_rx_byte made;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_predictor();
            predicted_bytes.delete();
        end else begin
            if (o_valid && !i_stall) begin
                if (predicted_bytes.size() == 0) begin
                    $error("unexpected byte: data_byte 0x%02h polarity_inverted %0b",
                           o_data_byte, o_polarity_inverted);
                    mismatches++;
                end else begin
                    want = predicted_bytes.pop_front();
                    if (o_data_byte !== want.value) begin
                        $error("data_byte: expected 0x%02h, actual 0x%02h",
                               want.value, o_data_byte);
                        mismatches++;
                    end
                    if (o_polarity_inverted !== want.inverted) begin
                        $error("polarity_inverted: expected %0b, actual %0b",
                               want.inverted, o_polarity_inverted);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                if (deframe_sample(i_sample_i, i_sample_q, made))
                    predicted_bytes.push_back(made);
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("iq_sync_word_byte_deframer_core regression: fail");
            $finish;
        end
    end

    // Stimulus building blocks
    function automatic void queue_pair(input int vi, input int vq);
        t_iq_word w;
        w.i_part = vi[SAMPLE_W-1:0];
        w.q_part = vq[SAMPLE_W-1:0];
        sample_fifo.push_back(w);
    endfunction

    // Put level a on the component that will be picked
    function automatic void queue_level(input int a);
        int m, other;
        m = (a < 0) ? -a : a;
        if ($urandom_range(0, 1) == 1) begin
            other = int'($urandom_range(0, 2 * m)) - m;
            if (other > 32767) other = 32767;
            queue_pair(other, a);
        end else if (m == 0) begin
            queue_pair(0, a);
        end else begin
            other = int'($urandom_range(0, 2 * m - 2)) - (m - 1);
            queue_pair(a, other);
        end
    endfunction

    function automatic void queue_bit(input bit high);
        if (high) queue_level(int'($urandom_range(32767, stim_thr)));
        else      queue_level(-int'($urandom_range(32768, stim_thr)));
    endfunction

    // Sub-threshold word, dropped by the block
    function automatic void queue_noise();
        if (stim_thr > 0)
            queue_level(int'($urandom_range(0, 2 * stim_thr - 2)) - (int'(stim_thr) - 1));
    endfunction

    function automatic int queue_frame(input bit use_inv);
        logic [HDR_W-1:0] hdr;
        hdr = use_inv ? stim_inv : stim_sync;
        for (int k = HDR_W - 1; k >= 0; k--) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_bit(hdr[k]);
        end
        for (int k = 0; k < BYTE_W; k++) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_bit(1'($urandom_range(0, 1)));
        end
        return HDR_W + BYTE_W;
    endfunction

    // Header cut short, then arbitrary bits
    function automatic int queue_broken();
        logic [HDR_W-1:0] hdr;
        int cut, tail;
        hdr  = $urandom_range(0, 1) ? stim_inv : stim_sync;
        cut  = $urandom_range(1, HDR_W - 1);
        tail = $urandom_range(1, BYTE_W);
        for (int k = HDR_W - 1; k >= HDR_W - cut; k--) queue_bit(hdr[k]);
        for (int k = 0; k < tail; k++) queue_bit(1'($urandom_range(0, 1)));
        return cut + tail;
    endfunction

    function automatic int queue_raw();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            queue_pair(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
        return n;
    endfunction

    function automatic void queue_random(input int target);
        int done, pick;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      done += queue_frame(1'($urandom_range(0, 1)));
            else if (pick < 85) done += queue_broken();
            else                done += queue_raw();
        end
    endfunction

    // Wait until every word is taken and every byte seen, then let the pipe empty
    task automatic drain();
        @(negedge i_clk);
        while (sample_fifo.size() != 0 || i_valid || predicted_bytes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] thr,
                             input logic [CFG_DATA_W-1:0] sync_w,
                             input logic [CFG_DATA_W-1:0] inv_w,
                             input bit quiet, input bit spare_write);
        if (spare_write) write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_IDX_THRESHOLD, thr);
        write_reg(CFG_IDX_SYNC, sync_w);
        write_reg(CFG_IDX_SYNC_INV, inv_w);
        stim_thr   = thr[THR_W-1:0];
        stim_sync  = sync_w[HDR_W-1:0];
        stim_inv   = inv_w[HDR_W-1:0];
        quiet_mode = quiet;
        queue_random(PHASE_WORDS);
        drain();
    endtask

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] shared_hdr;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full-scale corners, magnitude ties, threshold edge
        queue_pair(-32768, -32768);
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        queue_pair(1200, -1200);
        queue_pair(-1199, 1199);
        queue_pair(0, 0);
        queue_pair(-1200, 5);
        void'(queue_frame(1'b0));
        queue_random(PHASE_WORDS);
        drain();

        // Zero threshold, random headers, write to the spare index
        run_phase('0, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 1'b0, 1'b1);
        // Top threshold, both headers equal
        shared_hdr = CFG_DATA_W'($urandom);
        run_phase(15'd32767, shared_hdr, shared_hdr, 1'b0, 1'b0);
        // All-ones / all-zeros headers, no idling
        run_phase(CFG_DATA_W'($urandom_range(1, 4000)), 15'h01FF, '0, 1'b1, 1'b0);
        // Smallest nonzero threshold, swapped extremes
        run_phase(15'd1, '0, 15'h7FFF, 1'b0, 1'b1);
        // Back to reset values, no idling to the end
        run_phase(THRESHOLD_RST, CFG_DATA_W'(SYNC_RST), CFG_DATA_W'(SYNC_INV_RST), 1'b1, 1'b0);

        if (mismatches == 0 && predicted_bytes.size() == 0)
            $display("iq_sync_word_byte_deframer_core regression: pass");
        else
            $display("iq_sync_word_byte_deframer_core regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/iqd_pkg.sv
hw/rtl/iqd_front.sv
hw/rtl/iqd_fifo.sv
hw/rtl/iqd_back.sv
hw/rtl/iq_sync_word_byte_deframer_core.sv
bench/testbench.sv
